[rtl/pif_pkg.sv]
// ----------------------------------------------------------------------------
// pif_pkg: shared types and helpers of the integer text formatter
// Register codes, conversion codes, the front-to-back command record and the
// character lookup used by the back end.
// ----------------------------------------------------------------------------
package pif_pkg;

  localparam int MAX_FIELD_DEF = 64;
  localparam int QDEPTH_DEF    = 2;
  localparam int NDIG          = 22;  // enough for 64 bits in octal
  localparam int LEN_W         = 7;   // lengths up to 64

  // register indexes
  localparam logic [2:0] REG_CONV  = 3'd0;
  localparam logic [2:0] REG_SIZE  = 3'd1;
  localparam logic [2:0] REG_FLAGS = 3'd2;
  localparam logic [2:0] REG_WIDTH = 3'd3;
  localparam logic [2:0] REG_PREC  = 3'd4;

  // conversion codes
  localparam logic [2:0] CONV_SDEC = 3'd0;
  localparam logic [2:0] CONV_UDEC = 3'd1;
  localparam logic [2:0] CONV_HEXL = 3'd2;
  localparam logic [2:0] CONV_HEXU = 3'd3;
  localparam logic [2:0] CONV_OCT  = 3'd4;
  localparam logic [2:0] CONV_PTR  = 3'd5;

  // size codes
  localparam logic [1:0] SIZE_SHORT = 2'd0;
  localparam logic [1:0] SIZE_INT   = 2'd1;

  // flag bit positions
  localparam int FLAG_LEFT = 0;
  localparam int FLAG_ZPAD = 1;
  localparam int FLAG_PLUS = 2;
  localparam int FLAG_SPC  = 3;
  localparam int FLAG_ALT  = 4;

  typedef struct packed {
    logic [2:0]        conv;
    logic [1:0]        size;
    logic [4:0]        flags;
    logic [LEN_W-1:0]  width;
    logic signed [6:0] prec;
  } cfg_t;

  typedef logic [NDIG-1:0][3:0] digs_t;

  typedef struct packed {
    digs_t            digs;
    logic [4:0]       ndig;
    logic             upper;
    logic             has_sign;
    logic [7:0]       sign_ch;
    logic             has_pfx;
    logic [7:0]       pfx_ch;
    logic             nil;
    logic [LEN_W-1:0] zeros;
    logic [LEN_W-1:0] lead_pad;
    logic [LEN_W-1:0] trail_pad;
    logic [LEN_W-1:0] total;
  } cmd_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) c = 8'h30 + {4'd0, d};
    else if (upper) c = 8'h41 + {4'd0, d} - 8'd10;
    else c = 8'h61 + {4'd0, d} - 8'd10;
    return c;
  endfunction

endpackage

[rtl/printf_integer_formatter_unit.sv]
// ----------------------------------------------------------------------------
// printf_integer_formatter_unit: printf-style integer text generator
// Formats a 64-bit argument as %d %u %x %X %o or %p text, one character per
// output transfer, with width, precision, sign, alternate and pad rules.
// ----------------------------------------------------------------------------
// Conversion: decimal values pass S_LOAD, the double-dabble loop in S_CONV
//   (two bits per step), S_FIN1 and S_FIN2; hex, octal and pointer skip the
//   loop. The command then passes the queue and the registered output stage.
// Throughput: one character per cycle unless out_stall holds it; a new value is
//   taken once the last is queued; the double-dabble loop or the output lane sets it.
// Reset (rst, synchronous): registers return to their defaults, the queue and
//   both sequencers empty; no clearing pass.
module printf_integer_formatter_unit #(
  parameter int MAX_FIELD = pif_pkg::MAX_FIELD_DEF,
  parameter int QDEPTH    = pif_pkg::QDEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] raw_value,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        is_last,
  output logic        is_empty
);
  import pif_pkg::*;

  cfg_t        cfg;
  logic [2:0]  reg_idx;
  logic        wr_en;
  logic [6:0]  wdat7;

  cmd_t        push_cmd, head_cmd;
  logic        push, pop, q_full, q_empty;

  // Register file. Field width and precision are clamped as they are written
  // so that no field can grow past MAX_FIELD characters.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign wdat7   = pwdata[6:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.conv  <= CONV_SDEC;
      cfg.size  <= SIZE_INT;
      cfg.flags <= '0;
      cfg.width <= '0;
      cfg.prec  <= -7'sd1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CONV:  cfg.conv  <= pwdata[2:0];
        REG_SIZE:  cfg.size  <= pwdata[1:0];
        REG_FLAGS: cfg.flags <= pwdata[4:0];
        REG_WIDTH: cfg.width <= (wdat7 > 7'(MAX_FIELD)) ? 7'(MAX_FIELD) : wdat7;
        REG_PREC: begin
          // negative means no precision given
          if (wdat7[6])                      cfg.prec <= -7'sd1;
          else if (wdat7 > 7'(MAX_FIELD - 2)) cfg.prec <= 7'(MAX_FIELD - 2);
          else                               cfg.prec <= wdat7;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CONV:  prdata = {29'd0, cfg.conv};
      REG_SIZE:  prdata = {30'd0, cfg.size};
      REG_FLAGS: prdata = {27'd0, cfg.flags};
      REG_WIDTH: prdata = {25'd0, cfg.width};
      REG_PREC:  prdata = {{25{cfg.prec[6]}}, cfg.prec};
      default:   prdata = '0;
    endcase
  end

  // Front end: narrow, sign and split the value into digits, then size the
  // pad, sign, prefix, zero and digit segments of the field.
  pif_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .raw_value (raw_value),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  // Command queue: lets the next value convert while text still drains.
  pif_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (push_cmd),
    .pop    (pop),
    .rd_cmd (head_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  // Back end: walk the segments and drive one character per transfer from
  // a registered output stage.
  pif_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_cmd  (head_cmd),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .is_last   (is_last),
    .is_empty  (is_empty)
  );

endmodule

[rtl/pif_front.sv]
// ----------------------------------------------------------------------------
// pif_front: accept a raw value and turn it into a formatting command
// Narrow and sign the value, split it into digits and size every segment.
// ----------------------------------------------------------------------------
module pif_front (
  input  logic           clk,
  input  logic           rst,
  input  pif_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [63:0]    raw_value,
  output logic           push,
  output pif_pkg::cmd_t  push_cmd,
  input  logic           q_full
);
  import pif_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_CONV, S_FIN1, S_FIN2} state_t;

  state_t      state;
  logic [2:0]  mode;
  logic [63:0] mag;
  logic [63:0] sh;
  logic        has_sign;
  logic [7:0]  sign_ch;
  logic        nil;
  digs_t       digs;
  logic [4:0]  ndig;
  logic [4:0]  ndig_next;
  logic [4:0]  cnt;

  logic [2:0]  mode_in;
  logic [63:0] val_in;
  logic [63:0] mag_in;
  logic        neg_in;

  // one double-dabble bit: adjust then shift in
  function automatic digs_t dabble(input digs_t d, input logic b);
    logic [NDIG*4-1:0] f;
    for (int i = 0; i < NDIG; i++) begin
      if (d[i] >= 4'd5) d[i] = d[i] + 4'd3;
    end
    f = d;
    f = {f[NDIG*4-2:0], b};
    return digs_t'(f);
  endfunction

  always_comb begin
    mode_in = (cfg.conv > CONV_PTR) ? CONV_SDEC : cfg.conv;
    if (mode_in == CONV_PTR) val_in = raw_value;
    else if (cfg.size == SIZE_SHORT)
      val_in = (mode_in == CONV_SDEC) ? {{48{raw_value[15]}}, raw_value[15:0]}
                                      : {48'd0, raw_value[15:0]};
    else if (cfg.size == SIZE_INT)
      val_in = (mode_in == CONV_SDEC) ? {{32{raw_value[31]}}, raw_value[31:0]}
                                      : {32'd0, raw_value[31:0]};
    else val_in = raw_value;
    neg_in = (mode_in == CONV_SDEC) && val_in[63];
    mag_in = neg_in ? (64'd0 - val_in) : val_in;
  end

  assign in_stall = (state != S_IDLE);

  // digit count: highest nonzero digit, none for a zero value at precision 0
  always_comb begin
    ndig_next = 5'd1;
    for (int i = 1; i < NDIG; i++) begin
      if (digs[i] != 4'd0) ndig_next = 5'(i + 1);
    end
    if (cfg.prec == 7'sd0 && mag == 64'd0) ndig_next = 5'd0;
  end

  // segment sizing
  logic             prec_given;
  logic [7:0]       zeros8, body8, tot8, pad8;
  logic             has_pfx, zfill, left, alt, mag_zero;

  always_comb begin
    left       = cfg.flags[FLAG_LEFT];
    alt        = cfg.flags[FLAG_ALT];
    mag_zero   = (mag == 64'd0);
    prec_given = !cfg.prec[6];
    zeros8 = 8'd0;
    if (prec_given && ({1'b0, cfg.prec} > {3'd0, ndig}))
      zeros8 = {1'b0, cfg.prec} - {3'd0, ndig};
    if (mode == CONV_OCT && alt && !(zeros8 != 8'd0 || (ndig != 5'd0 && mag_zero)))
      zeros8 = zeros8 + 8'd1;
    has_pfx = !nil && (mode == CONV_PTR ||
              (alt && !mag_zero && (mode == CONV_HEXL || mode == CONV_HEXU)));
    body8 = {7'd0, has_sign} + (has_pfx ? 8'd2 : 8'd0);
    tot8  = nil ? 8'd5 : (body8 + zeros8 + {3'd0, ndig});
    pad8  = ({1'b0, cfg.width} > tot8) ? ({1'b0, cfg.width} - tot8) : 8'd0;
    zfill = !nil && !left && cfg.flags[FLAG_ZPAD] && !prec_given;

    push_cmd.digs      = digs;
    push_cmd.ndig      = nil ? 5'd0 : ndig;
    push_cmd.upper     = (mode == CONV_HEXU);
    push_cmd.has_sign  = has_sign && !nil;
    push_cmd.sign_ch   = sign_ch;
    push_cmd.has_pfx   = has_pfx;
    push_cmd.pfx_ch    = (mode == CONV_HEXU) ? 8'h58 : 8'h78;
    push_cmd.nil       = nil;
    push_cmd.zeros     = nil ? '0 : (zfill ? LEN_W'(zeros8 + pad8) : LEN_W'(zeros8));
    push_cmd.lead_pad  = (!left && !zfill) ? LEN_W'(pad8) : '0;
    push_cmd.trail_pad = left ? LEN_W'(pad8) : '0;
    push_cmd.total     = LEN_W'(tot8 + pad8);
  end

  assign push = (state == S_FIN2) && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode     <= mode_in;
            mag      <= mag_in;
            nil      <= (mode_in == CONV_PTR) && (raw_value == 64'd0);
            has_sign <= neg_in || ((mode_in == CONV_SDEC) &&
                        (cfg.flags[FLAG_PLUS] || cfg.flags[FLAG_SPC]));
            sign_ch  <= neg_in ? 8'h2D : (cfg.flags[FLAG_PLUS] ? 8'h2B : 8'h20);
            state    <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (mode == CONV_SDEC || mode == CONV_UDEC) begin
            digs  <= '0;
            sh    <= mag;
            cnt   <= '0;
            state <= S_CONV;
          end else begin
            for (int i = 0; i < NDIG; i++) begin
              if (mode == CONV_OCT) begin
                if (i < 21) digs[i] <= {1'b0, mag[3*i +: 3]};
                else        digs[i] <= {3'd0, mag[63]};
              end else begin
                if (i < 16) digs[i] <= mag[4*i +: 4];
                else        digs[i] <= 4'd0;
              end
            end
            state <= S_FIN1;
          end
        end
        S_CONV: begin
          // two bits a cycle
          digs <= dabble(dabble(digs, sh[63]), sh[62]);
          sh   <= {sh[61:0], 2'b00};
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) state <= S_FIN1;
        end
        S_FIN1: begin
          ndig  <= ndig_next;
          state <= S_FIN2;
        end
        S_FIN2: begin
          if (!q_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/pif_queue.sv]
// ----------------------------------------------------------------------------
// pif_queue: short command queue between front and back end
// Holds formatting commands so that either side can stall on its own.
// ----------------------------------------------------------------------------
module pif_queue #(
  parameter int DEPTH = pif_pkg::QDEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pif_pkg::cmd_t wr_cmd,
  input  logic          pop,
  output pif_pkg::cmd_t rd_cmd,
  output logic          full,
  output logic          empty
);
  import pif_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign rd_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full)
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop && !empty)
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      count <= count + CW'(push && !full) - CW'(pop && !empty);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

[rtl/pif_back.sv]
// ----------------------------------------------------------------------------
// pif_back: emit the text of one command, one character a cycle unless stalled
// Walk the segments of the field and drive the registered output.
// ----------------------------------------------------------------------------
module pif_back (
  input  logic          clk,
  input  logic          rst,
  input  pif_pkg::cmd_t head_cmd,
  input  logic          q_empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_char,
  output logic          is_last,
  output logic          is_empty
);
  import pif_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_RUN, B_EMPTY} state_t;
  typedef enum logic [2:0] {
    P_LEAD, P_NIL, P_SIGN, P_PFX0, P_PFX1, P_ZERO, P_DIG, P_TRAIL
  } phase_t;

  state_t           state;
  phase_t           phase;
  cmd_t             cur;
  logic [LEN_W-1:0] cnt;
  logic [LEN_W-1:0] rem;

  function automatic logic [LEN_W-1:0] plen(input cmd_t c, input phase_t p);
    logic [LEN_W-1:0] n;
    case (p)
      P_LEAD:  n = c.lead_pad;
      P_NIL:   n = c.nil ? LEN_W'(5) : '0;
      P_SIGN:  n = LEN_W'(c.has_sign);
      P_PFX0:  n = LEN_W'(c.has_pfx);
      P_PFX1:  n = LEN_W'(c.has_pfx);
      P_ZERO:  n = c.zeros;
      P_DIG:   n = LEN_W'(c.ndig);
      P_TRAIL: n = c.trail_pad;
      default: n = '0;
    endcase
    return n;
  endfunction

  function automatic phase_t first_ph(input cmd_t c, input int start);
    phase_t p;
    logic   found;
    p = P_TRAIL;
    found = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!found && k >= start && plen(c, phase_t'(3'(k))) != '0) begin
        p = phase_t'(3'(k));
        found = 1'b1;
      end
    end
    return p;
  endfunction

  logic [7:0]       ch;
  logic [LEN_W-1:0] didx;
  logic             can_load;

  always_comb begin
    didx = LEN_W'(cur.ndig) - LEN_W'(1) - cnt;
    case (phase)
      P_SIGN:  ch = cur.sign_ch;
      P_PFX0:  ch = 8'h30;
      P_PFX1:  ch = cur.pfx_ch;
      P_ZERO:  ch = 8'h30;
      P_DIG:   ch = digit_char(cur.digs[didx[4:0]], cur.upper);
      P_NIL: begin
        case (cnt[2:0])
          3'd0:    ch = 8'h28;
          3'd1:    ch = 8'h6E;
          3'd2:    ch = 8'h69;
          3'd3:    ch = 8'h6C;
          default: ch = 8'h29;
        endcase
      end
      default: ch = 8'h20;
    endcase
  end

  assign can_load = !out_valid || !out_stall;
  assign pop      = (state == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (can_load) out_valid <= 1'b0;
          if (!q_empty) begin
            cur   <= head_cmd;
            cnt   <= '0;
            rem   <= head_cmd.total;
            phase <= first_ph(head_cmd, 0);
            state <= (head_cmd.total == '0) ? B_EMPTY : B_RUN;
          end
        end
        B_RUN: begin
          if (can_load) begin
            out_valid <= 1'b1;
            out_char  <= ch;
            is_last   <= (rem == LEN_W'(1));
            is_empty  <= 1'b0;
            rem       <= rem - LEN_W'(1);
            if (rem == LEN_W'(1)) state <= B_IDLE;
            else if (cnt + LEN_W'(1) < plen(cur, phase)) cnt <= cnt + LEN_W'(1);
            else begin
              cnt   <= '0;
              phase <= first_ph(cur, int'(phase) + 1);
            end
          end
        end
        B_EMPTY: begin
          if (can_load) begin
            out_valid <= 1'b1;
            out_char  <= 8'h00;
            is_last   <= 1'b1;
            is_empty  <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: begin
          if (can_load) out_valid <= 1'b0;
          state <= B_IDLE;
        end
      endcase
    end
  end

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> is_last && out_char == 8'h00)
    else $error("empty result malformed");

  a_rem_live: assert property (@(posedge clk) disable iff (rst)
    state == B_RUN |-> rem != '0)
    else $error("running with nothing left");

  a_cnt_in_phase: assert property (@(posedge clk) disable iff (rst)
    state == B_RUN |-> cnt < plen(cur, phase))
    else $error("segment counter past segment");

endmodule

[tb/sv/printf_integer_formatter_unit_test.sv]
// ----------------------------------------------------------------------------
// printf_integer_formatter_unit_test: self-checking bench of the text formatter
// Drives raw values through the valid/stall input, programs the five registers
// over the APB port between phases, predicts each character and compares every
// output transfer against the oldest expected character.
// ----------------------------------------------------------------------------
module printf_integer_formatter_unit_test;
  import pif_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty;
  } char_t;

  // one row of the directed table: settings, value, optional typed-in text
  typedef struct {
    logic [2:0]  conv;
    logic [1:0]  size;
    logic [4:0]  flags;
    logic [6:0]  width;
    logic [6:0]  prec;
    logic [63:0] value;
    string       text;   // "" means: trust the predictor
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] raw_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [7:0]  out_char;
  logic        is_last, is_empty;

  // predictor copy of the registers
  logic [2:0]        m_conv;
  logic [1:0]        m_size;
  logic [4:0]        m_flags;
  int                m_width;
  int                m_prec;

  char_t expected_chars[$];
  int    errors = 0;
  int    idle_cycles = 0;
  bit    long_hold = 1'b0;

  printf_integer_formatter_unit u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mirror a register write, clamping exactly as the block does at write time
  function automatic void note_write(input logic [2:0] idx, input logic [31:0] v);
    case (idx)
      REG_CONV:  m_conv  = v[2:0];
      REG_SIZE:  m_size  = v[1:0];
      REG_FLAGS: m_flags = v[4:0];
      REG_WIDTH: m_width = (v[6:0] > 64) ? 64 : int'(v[6:0]);
      REG_PREC:  m_prec  = v[6] ? -1 : ((v[5:0] > 62) ? 62 : int'(v[5:0]));
      default: ;
    endcase
  endfunction

  // build the text of one value under the current registers
  function automatic string format_value(input logic [63:0] raw);
    string       txt, digs, pre, set;
    logic [2:0]  mode;
    logic [63:0] mag, v;
    logic [7:0]  sign;
    bit          left, zpad, plus, spc, alt;
    int          zeros, pad, base, di;
    mode = (m_conv > CONV_PTR) ? CONV_SDEC : m_conv;
    left = m_flags[FLAG_LEFT]; zpad = m_flags[FLAG_ZPAD];
    plus = m_flags[FLAG_PLUS]; spc = m_flags[FLAG_SPC]; alt = m_flags[FLAG_ALT];
    txt = ""; digs = ""; pre = ""; sign = 8'h00;
    if (mode == CONV_PTR && raw == 0) begin
      pad = (m_width > 5) ? m_width - 5 : 0;
      txt = "(nil)";
      repeat (pad) txt = left ? {txt, " "} : {" ", txt};
      return txt;
    end
    if (mode == CONV_PTR) mag = raw;
    else if (mode == CONV_SDEC) begin
      if (m_size == SIZE_SHORT) v = {{48{raw[15]}}, raw[15:0]};
      else if (m_size == SIZE_INT) v = {{32{raw[31]}}, raw[31:0]};
      else v = raw;
      if (v[63]) begin
        sign = "-";
        mag = -v;
      end else begin
        mag = v;
        if (plus) sign = "+";
        else if (spc) sign = " ";
      end
    end else begin
      if (m_size == SIZE_SHORT) mag = {48'd0, raw[15:0]};
      else if (m_size == SIZE_INT) mag = {32'd0, raw[31:0]};
      else mag = raw;
    end
    base = (mode == CONV_HEXL || mode == CONV_HEXU || mode == CONV_PTR) ? 16 :
           (mode == CONV_OCT) ? 8 : 10;
    set = (mode == CONV_HEXU) ? "0123456789ABCDEF" : "0123456789abcdef";
    if (!(m_prec == 0 && mag == 0)) begin
      v = mag;
      do begin
        di = int'(v % base);
        digs = {set.substr(di, di), digs};
        v = v / base;
      end while (v != 0);
    end
    zeros = (m_prec > digs.len()) ? m_prec - digs.len() : 0;
    if (mode == CONV_PTR || (alt && mag != 0 && (mode == CONV_HEXL || mode == CONV_HEXU)))
      pre = (mode == CONV_HEXU) ? "0X" : "0x";
    else if (alt && mode == CONV_OCT) begin
      if (!(zeros > 0 || (digs.len() > 0 && digs[0] == "0"))) zeros++;
    end
    if (sign != 0) pre = {string'(sign), pre};
    pad = m_width - (pre.len() + zeros + digs.len());
    if (pad < 0) pad = 0;
    repeat (zeros) digs = {"0", digs};
    if (left) begin
      txt = {pre, digs};
      repeat (pad) txt = {txt, " "};
    end else if (zpad && m_prec < 0) begin
      repeat (pad) digs = {"0", digs};
      txt = {pre, digs};
    end else begin
      txt = {pre, digs};
      repeat (pad) txt = {" ", txt};
    end
    return txt;
  endfunction

  // queue the characters of one text
  function automatic void queue_text(input string txt);
    char_t c;
    if (txt.len() == 0) begin
      c = '{8'h00, 1'b1, 1'b1};
      expected_chars.push_back(c);
    end
    for (int i = 0; i < txt.len() && i < 64; i++) begin
      c = '{txt[i], (i == txt.len() - 1 || i == 63), 1'b0};
      expected_chars.push_back(c);
    end
  endfunction

  // two-phase APB write
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    note_write(idx, v);
  endtask

  // drop the input, wait for the block to drain, then a margin
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic program_all(input logic [2:0] c, input logic [1:0] s, input logic [4:0] f,
                             input logic [31:0] w, input logic [31:0] p);
    reg_write(REG_CONV, {29'd0, c});
    reg_write(REG_SIZE, {30'd0, s});
    reg_write(REG_FLAGS, {27'd0, f});
    reg_write(REG_WIDTH, w);
    reg_write(REG_PREC, p);
  endtask

  // offer one value after an optional random idle gap; hold it until the transfer happens
  task automatic send_value(input logic [63:0] v, input bit gaps);
    int n;
    n = gaps ? int'($urandom_range(0, 15)) : 0;
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_value <= v;
    do @(posedge clk); while (in_stall);
    queue_text(format_value(v));
  endtask

  function automatic logic [63:0] rand_value;
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = v >> $urandom_range(0, 63);
      2: v = ~(v >> $urandom_range(0, 63));
      default: ;
    endcase
    return v;
  endfunction

  // receiver: random wait before each character, one long hold-off when asked
  initial begin
    int holdoff;
    int n;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        for (holdoff = 0; holdoff < 400; holdoff++) @(posedge clk);
        long_hold = 1'b0;
      end
      n = int'($urandom_range(0, 15));
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // checker: compare every output transfer with the oldest expectation
  always @(posedge clk) begin
    char_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected char expected none actual %h", $time, out_char);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (want.ch !== out_char || want.last !== is_last || want.empty !== is_empty) begin
          $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                   want.ch, want.last, want.empty, out_char, is_last, is_empty);
          errors++;
        end
      end
    end
  end

  // watchdog: count cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  row_t rows[] = '{
    '{CONV_SDEC, SIZE_INT,   5'h00, 7'd0,  7'h7F, 64'd0,                 "0"},
    '{CONV_SDEC, SIZE_INT,   5'h00, 7'd0,  7'h7F, 64'h0000_0000_8000_0000, "-2147483648"},
    '{CONV_SDEC, SIZE_SHORT, 5'h04, 7'd0,  7'h7F, 64'h7FFF,              "+32767"},
    '{CONV_SDEC, SIZE_SHORT, 5'h08, 7'd0,  7'h7F, 64'h1,                 " 1"},
    '{CONV_SDEC, 2'd2,       5'h00, 7'd0,  7'h7F, 64'h8000_0000_0000_0000,
      "-9223372036854775808"},
    '{CONV_UDEC, 2'd2,       5'h00, 7'd0,  7'h7F, 64'hFFFF_FFFF_FFFF_FFFF,
      "18446744073709551615"},
    '{CONV_SDEC, SIZE_INT,   5'h00, 7'd0,  7'd0,  64'd0,                 ""},
    '{CONV_HEXL, SIZE_INT,   5'h10, 7'd0,  7'h7F, 64'hABCD,              "0xabcd"},
    '{CONV_HEXU, SIZE_INT,   5'h10, 7'd0,  7'h7F, 64'hABCD,              "0XABCD"},
    '{CONV_HEXL, SIZE_INT,   5'h10, 7'd0,  7'h7F, 64'd0,                 "0"},
    '{CONV_OCT,  SIZE_INT,   5'h10, 7'd0,  7'd0,  64'd0,                 "0"},
    '{CONV_OCT,  SIZE_INT,   5'h10, 7'd0,  7'h7F, 64'd8,                 "010"},
    '{CONV_OCT,  SIZE_SHORT, 5'h14, 7'd0,  7'd4,  64'd8,                 ""},
    '{CONV_PTR,  SIZE_SHORT, 5'h00, 7'd8,  7'h7F, 64'd0,                 "   (nil)"},
    '{CONV_PTR,  SIZE_SHORT, 5'h03, 7'd8,  7'd3,  64'd0,                 "(nil)   "},
    '{CONV_PTR,  SIZE_SHORT, 5'h1C, 7'd0,  7'h7F, 64'hFFFF_FFFF_FFFF_FFFF, ""},
    '{CONV_SDEC, SIZE_INT,   5'h02, 7'd8,  7'h7F, 64'hFFFF_FFFE,         "-0000002"},
    '{CONV_SDEC, SIZE_INT,   5'h02, 7'd8,  7'd3,  64'd5,                 "     005"},
    '{CONV_SDEC, SIZE_INT,   5'h03, 7'd6,  7'h7F, 64'd42,                ""},
    '{CONV_HEXL, SIZE_INT,   5'h12, 7'd10, 7'h7F, 64'h1F,                "0x0000001f"},
    '{CONV_UDEC, SIZE_INT,   5'h00, 7'd127, 7'd127, 64'd7,              ""},
    '{CONV_HEXU, 2'd3,       5'h01, 7'd64, 7'h7F, 64'hDEAD_BEEF_0123_4567, ""},
    '{3'd7,      SIZE_INT,   5'h0C, 7'd0,  7'h7F, 64'h0000_0000_FFFF_FFFF, "-1"},
    '{CONV_SDEC, SIZE_INT,   5'h00, 7'd0,  7'h40, 64'd3,                 "3"}
  };

  initial begin
    logic [2:0] c;
    note_write(REG_CONV, 0); note_write(REG_SIZE, 1); note_write(REG_FLAGS, 0);
    note_write(REG_WIDTH, 0); note_write(REG_PREC, 32'h7F);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // directed table: program each row, then check typed-in text if present
    foreach (rows[i]) begin
      drain();
      program_all(rows[i].conv, rows[i].size, rows[i].flags, {25'd0, rows[i].width},
                  {25'd0, rows[i].prec});
      if (rows[i].text.len() != 0 && format_value(rows[i].value) != rows[i].text) begin
        $display("%0t: row %0d expected %s actual %s", $time, i, rows[i].text,
                 format_value(rows[i].value));
        errors++;
      end
      send_value(rows[i].value, 1'b1);
    end
    // random phases; the second keeps sending with no gaps under a long hold-off
    for (int ph = 0; ph < 20; ph++) begin
      drain();
      c = 3'($urandom_range(0, 7));
      program_all(c, 2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                  ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 24),
                  ($urandom_range(0, 2) == 0) ? 32'h40 | $urandom_range(0, 63)
                                              : $urandom_range(0, 70));
      if (ph == 1) long_hold = 1'b1;
      for (int k = 0; k < 20; k++) send_value(rand_value(), ph != 1);
    end
    drain();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
